// ----- rtl/tbik_pkg.sv -----
package tbik_pkg;

    localparam int WORK_FRAC    = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int ANG_W        = 36;
    // abs, leading-one search, normalize, 30 rotations, quadrant fix
    localparam int CORDIC_LAT   = 3 + CORDIC_STEPS + 1;
    // special-case decode, then one quotient bit per stage
    localparam int DIV_LAT      = 1 + WORK_FRAC;
    localparam int ROOT_N       = 62;
    // square, subtract, root, atan2
    localparam int ACOS_LAT     = 2 + ROOT_N / 2 + CORDIC_LAT;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [31:0]      ONE_Q30     = 32'sd1073741824;

    typedef logic signed [ANG_W-1:0] ang_t;
    typedef logic signed [31:0]      cosv_t;

    // truncated Q30 atan(2^-i)
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        begin
            case (i)
                0:  v = 32'd843314856;
                1:  v = 32'd497837829;
                2:  v = 32'd263043836;
                3:  v = 32'd133525158;
                4:  v = 32'd67021686;
                5:  v = 32'd33543515;
                6:  v = 32'd16775850;
                7:  v = 32'd8388437;
                8:  v = 32'd4194282;
                9:  v = 32'd2097149;
                10: v = 32'd1048575;
                11: v = 32'd524287;
                12: v = 32'd262143;
                13: v = 32'd131071;
                14: v = 32'd65535;
                15: v = 32'd32767;
                16: v = 32'd16383;
                17: v = 32'd8191;
                18: v = 32'd4095;
                19: v = 32'd2047;
                20: v = 32'd1023;
                21: v = 32'd511;
                22: v = 32'd255;
                23: v = 32'd127;
                24: v = 32'd63;
                25: v = 32'd31;
                26: v = 32'd15;
                27: v = 32'd7;
                28: v = 32'd3;
                29: v = 32'd1;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- rtl/tbik_dly.sv -----
module tbik_dly #(
    parameter int WD = 8,
    parameter int DP = 1
) (
    input  logic          clk,
    input  logic [WD-1:0] d,
    output logic [WD-1:0] q
);

    logic [WD-1:0] sr_reg [0:DP-1];

    always_ff @(posedge clk)
    begin
        sr_reg[0] <= d;
        for (int i = 1; i < DP; i++)
        begin
            sr_reg[i] <= sr_reg[i-1];
        end
    end

    assign q = sr_reg[DP-1];

endmodule

// ----- rtl/tbik_isqrt.sv -----
// pipelined restoring square root, one root bit per stage
module tbik_isqrt #(
    parameter int N = 66
) (
    input  logic             clk,
    input  logic [N-1:0]     rad,
    output logic [N/2-1:0]   root
);

    localparam int RN = N / 2;
    localparam int RW = RN + 2;

    logic [N-1:0]  rad_reg  [0:RN];
    logic [RW-1:0] rem_reg  [0:RN];
    logic [RN-1:0] root_reg [0:RN];

    always_comb
    begin
        rad_reg[0]  = rad;
        rem_reg[0]  = '0;
        root_reg[0] = '0;
    end

    for (genvar k = 0; k < RN; k++) begin : g_step
        logic [RW-1:0] rem_next;
        logic [RW-1:0] trial;
        always_comb
        begin
            rem_next = {rem_reg[k][RW-3:0], rad_reg[k][N-1:N-2]};
            trial    = {root_reg[k], 2'b01};
        end
        always_ff @(posedge clk)
        begin
            rad_reg[k+1] <= {rad_reg[k][N-3:0], 2'b00};
            if (rem_next >= trial)
            begin
                rem_reg[k+1]  <= rem_next - trial;
                root_reg[k+1] <= {root_reg[k][RN-2:0], 1'b1};
            end
            else
            begin
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= {root_reg[k][RN-2:0], 1'b0};
            end
        end
    end

    assign root = root_reg[RN];

endmodule

// ----- rtl/tbik_cordic.sv -----
// pipelined vectoring atan2(y, x), Q30 radians
module tbik_cordic #(
    parameter int IW = 33
) (
    input  logic                 clk,
    input  logic signed [IW-1:0] y,
    input  logic signed [IW-1:0] x,
    output tbik_pkg::ang_t       z
);

    localparam int PW = $clog2(IW);
    localparam int NS = tbik_pkg::CORDIC_STEPS;

    typedef struct packed {
        logic xneg;
        logic yneg;
        logic zero;
    } quad_t;

    logic [IW-1:0] ax1_reg, ay1_reg, ax2_reg, ay2_reg;
    quad_t         q1_reg, q2_reg;
    logic [PW-1:0] pos2_reg;
    logic [IW-1:0] m1;
    logic [PW-1:0] pos1;
    logic [IW+29:0] axw, ayw;

    logic signed [33:0]  cx_reg [0:NS];
    logic signed [33:0]  cy_reg [0:NS];
    tbik_pkg::ang_t      zz_reg [0:NS];
    quad_t               q_reg  [0:NS];
    tbik_pkg::ang_t      z_reg;

    always_ff @(posedge clk)
    begin
        ax1_reg <= x[IW-1] ? IW'(-x) : IW'(x);
        ay1_reg <= y[IW-1] ? IW'(-y) : IW'(y);
        q1_reg  <= '{xneg: x[IW-1], yneg: y[IW-1], zero: (x == '0) && (y == '0)};
    end

    always_comb
    begin
        m1   = (ax1_reg > ay1_reg) ? ax1_reg : ay1_reg;
        pos1 = '0;
        for (int i = 0; i < IW; i++)
        begin
            if (m1[i])
                pos1 = i[PW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        ax2_reg  <= ax1_reg;
        ay2_reg  <= ay1_reg;
        pos2_reg <= pos1;
        q2_reg   <= q1_reg;
    end

    // bring the larger magnitude into [2^29, 2^30)
    always_comb
    begin
        if (int'(pos2_reg) >= 29)
        begin
            axw = {30'd0, ax2_reg} >> (int'(pos2_reg) - 29);
            ayw = {30'd0, ay2_reg} >> (int'(pos2_reg) - 29);
        end
        else
        begin
            axw = {30'd0, ax2_reg} << (29 - int'(pos2_reg));
            ayw = {30'd0, ay2_reg} << (29 - int'(pos2_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg[0] <= {3'b000, axw[30:0]};
        cy_reg[0] <= {3'b000, ayw[30:0]};
        zz_reg[0] <= '0;
        q_reg[0]  <= q2_reg;
    end

    for (genvar i = 0; i < NS; i++) begin : g_rot
        localparam tbik_pkg::ang_t AT = tbik_pkg::ang_t'(tbik_pkg::atan_q30(i));
        always_ff @(posedge clk)
        begin
            q_reg[i+1] <= q_reg[i];
            if (cy_reg[i] >= 0)
            begin
                cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                zz_reg[i+1] <= zz_reg[i] + AT;
            end
            else
            begin
                cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                zz_reg[i+1] <= zz_reg[i] - AT;
            end
        end
    end

    // quadrant fix-up
    always_ff @(posedge clk)
    begin
        if (q_reg[NS].zero)
            z_reg <= '0;
        else if (q_reg[NS].xneg && q_reg[NS].yneg)
            z_reg <= zz_reg[NS] - tbik_pkg::PI_Q30;
        else if (q_reg[NS].xneg)
            z_reg <= tbik_pkg::PI_Q30 - zz_reg[NS];
        else if (q_reg[NS].yneg)
            z_reg <= -zz_reg[NS];
        else
            z_reg <= zz_reg[NS];
    end

    assign z = z_reg;

endmodule

// ----- rtl/tbik_div.sv -----
// clamped cosine num/den in Q30, one quotient bit per stage
module tbik_div (
    input  logic               clk,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output tbik_pkg::cosv_t    q
);

    localparam int NS = tbik_pkg::WORK_FRAC;

    logic [63:0]        r_reg   [0:NS];
    logic [63:0]        d_reg   [0:NS];
    logic [NS-1:0]      q_reg   [0:NS];
    logic               neg_reg [0:NS];
    logic               sp_reg  [0:NS];
    tbik_pkg::cosv_t    sv_reg  [0:NS];

    always_ff @(posedge clk)
    begin
        r_reg[0]   <= num[63] ? 64'(-num) : 64'(num);
        d_reg[0]   <= den;
        q_reg[0]   <= '0;
        neg_reg[0] <= num[63];
        sp_reg[0]  <= (den == 0) || (num >= den) || (num <= -den);
        if (den == 0)
            sv_reg[0] <= (num > 0) ? tbik_pkg::ONE_Q30
                       : ((num < 0) ? -tbik_pkg::ONE_Q30 : '0);
        else if (num >= den)
            sv_reg[0] <= tbik_pkg::ONE_Q30;
        else
            sv_reg[0] <= -tbik_pkg::ONE_Q30;
    end

    for (genvar i = 0; i < NS; i++) begin : g_bit
        logic [63:0] rs;
        assign rs = {r_reg[i][62:0], 1'b0};
        always_ff @(posedge clk)
        begin
            d_reg[i+1]   <= d_reg[i];
            neg_reg[i+1] <= neg_reg[i];
            sp_reg[i+1]  <= sp_reg[i];
            sv_reg[i+1]  <= sv_reg[i];
            if (rs >= d_reg[i])
            begin
                r_reg[i+1] <= rs - d_reg[i];
                q_reg[i+1] <= {q_reg[i][NS-2:0], 1'b1};
            end
            else
            begin
                r_reg[i+1] <= rs;
                q_reg[i+1] <= {q_reg[i][NS-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (sp_reg[NS])
            q = sv_reg[NS];
        else if (neg_reg[NS])
            q = -tbik_pkg::cosv_t'({2'b00, q_reg[NS]});
        else
            q = tbik_pkg::cosv_t'({2'b00, q_reg[NS]});
    end

endmodule

// ----- rtl/tbik_acos.sv -----
// acos(c) = atan2(sqrt(1 - c^2), c) in Q30
module tbik_acos (
    input  logic            clk,
    input  tbik_pkg::cosv_t c,
    output tbik_pkg::ang_t  a
);

    localparam int RN = tbik_pkg::ROOT_N / 2;

    tbik_pkg::cosv_t c1_reg, c2_reg, cd;
    logic [60:0]     csq_reg;
    logic [tbik_pkg::ROOT_N-1:0] s2_reg;
    logic [63:0]     prod;
    logic [RN-1:0]   root;

    assign prod = 64'(c) * 64'(c);

    always_ff @(posedge clk)
    begin
        c1_reg  <= c;
        csq_reg <= prod[60:0];
        c2_reg  <= c1_reg;
        s2_reg  <= {1'b0, 61'(62'd1 << 60) - csq_reg};
    end

    tbik_isqrt #(.N(tbik_pkg::ROOT_N)) u_root (
        .clk  (clk),
        .rad  (s2_reg),
        .root (root)
    );

    tbik_dly #(.WD(32), .DP(RN)) u_cdly (
        .clk (clk),
        .d   (c2_reg),
        .q   (cd)
    );

    tbik_cordic #(.IW(32)) u_atan (
        .clk (clk),
        .y   ({1'b0, root}),
        .x   (cd),
        .z   (a)
    );

endmodule

// ----- rtl/two_bone_ik_angle_solver.sv -----
// Two-bone IK angle solver, fully pipelined: one item per cycle, busy always low.
// Stages from start to done: length roots (COORD_WIDTH+1 stages), cosine divider (31),
// acos square and root (2 + 31), atan2 CORDIC (34), plus 9 stages for differences,
// squares, sums, reach, scaling, products, cosine terms and the output register.
// Reset (rst_n, async, active low) clears only the valid chain; the receiver cannot stall done.
module two_bone_ik_angle_solver #(
    parameter int COORD_WIDTH     = 32,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [COORD_WIDTH-1:0]   hip_x,
    input  logic signed [COORD_WIDTH-1:0]   hip_y,
    input  logic signed [COORD_WIDTH-1:0]   hip_z,
    input  logic signed [COORD_WIDTH-1:0]   knee_x,
    input  logic signed [COORD_WIDTH-1:0]   knee_y,
    input  logic signed [COORD_WIDTH-1:0]   knee_z,
    input  logic signed [COORD_WIDTH-1:0]   foot_x,
    input  logic signed [COORD_WIDTH-1:0]   foot_y,
    input  logic signed [COORD_WIDTH-1:0]   foot_z,
    input  logic signed [COORD_WIDTH-1:0]   goal_x,
    input  logic signed [COORD_WIDTH-1:0]   goal_y,
    input  logic signed [COORD_WIDTH-1:0]   goal_z,
    output logic                            done,
    output logic signed [ANGLE_FRAC_BITS+3:0] hip_angle,
    output logic signed [ANGLE_FRAC_BITS+3:0] knee_angle,
    output logic                            reached,
    output logic                            degenerate
);

    localparam int DW  = COORD_WIDTH + 1;       // coordinate difference
    localparam int SQW = 2 * COORD_WIDTH + 2;   // sum of three squares
    localparam int LW  = COORD_WIDTH + 1;       // bone length
    localparam int SW  = $clog2(LW + 1);        // normalizing shift
    localparam int AW  = ANGLE_FRAC_BITS + 4;
    localparam int SH  = tbik_pkg::WORK_FRAC - ANGLE_FRAC_BITS;

    // pipeline depths (registers from start)
    localparam int L_DIFF = 1;
    localparam int L_LEN  = L_DIFF + 2 + LW;
    localparam int L_COS  = L_LEN + 5;
    localparam int L_ACOS = L_COS + tbik_pkg::DIV_LAT + tbik_pkg::ACOS_LAT;
    localparam int L_OUT  = L_ACOS + 1;
    localparam int L_ELEV = L_DIFF + tbik_pkg::CORDIC_LAT;

    typedef struct packed {
        logic degen;
        logic far;
    } reach_t;

    // valid chain
    logic [L_OUT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[L_OUT-2:0], start};
    end

    assign busy = 1'b0;
    assign done = vld_reg[L_OUT-1];

    // stage 1: differences (upper bone, lower bone, hip to goal)
    logic signed [DW-1:0] d_reg [0:8];

    always_ff @(posedge clk)
    begin
        d_reg[0] <= DW'(knee_x) - DW'(hip_x);
        d_reg[1] <= DW'(knee_y) - DW'(hip_y);
        d_reg[2] <= DW'(knee_z) - DW'(hip_z);
        d_reg[3] <= DW'(foot_x) - DW'(knee_x);
        d_reg[4] <= DW'(foot_y) - DW'(knee_y);
        d_reg[5] <= DW'(foot_z) - DW'(knee_z);
        d_reg[6] <= DW'(goal_x) - DW'(hip_x);
        d_reg[7] <= DW'(goal_y) - DW'(hip_y);
        d_reg[8] <= DW'(goal_z) - DW'(hip_z);
    end

    // elevation atan2(dy, dz) runs beside the length path
    tbik_pkg::ang_t elev, elev_d;

    tbik_cordic #(.IW(DW)) u_elev (
        .clk (clk),
        .y   (d_reg[7]),
        .x   (d_reg[8]),
        .z   (elev)
    );

    tbik_dly #(.WD(tbik_pkg::ANG_W), .DP(L_ACOS - L_ELEV)) u_elev_dly (
        .clk (clk),
        .d   (elev),
        .q   (elev_d)
    );

    // stage 2: squares, stage 3: sums
    logic [SQW-1:0] sq_reg  [0:8];
    logic [SQW-1:0] sum_reg [0:2];
    logic [LW-1:0]  len     [0:2];

    for (genvar i = 0; i < 9; i++) begin : g_sq
        logic signed [2*DW-1:0] p;
        assign p = d_reg[i] * d_reg[i];
        always_ff @(posedge clk)
        begin
            sq_reg[i] <= SQW'(p);
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_len
        always_ff @(posedge clk)
        begin
            sum_reg[j] <= sq_reg[3*j] + sq_reg[3*j+1] + sq_reg[3*j+2];
        end
        tbik_isqrt #(.N(SQW)) u_sqrt (
            .clk  (clk),
            .rad  (sum_reg[j]),
            .root (len[j])
        );
    end

    // stage D: reach test and largest length
    reach_t         rch_reg, rch_d;
    logic [LW-1:0]  l0_reg, l1_reg, l2_reg, mx_reg;
    logic [LW-1:0]  l0e_reg, l1e_reg, l2e_reg;
    logic [SW-1:0]  s_reg, s_next;
    logic [29:0]    a0_reg, a1_reg, a2_reg;

    always_ff @(posedge clk)
    begin
        rch_reg.degen <= (len[0] == '0) || (len[1] == '0) || (len[2] == '0);
        rch_reg.far   <= ({1'b0, len[0]} + {1'b0, len[1]}) < {1'b0, len[2]};
        l0_reg <= len[0];
        l1_reg <= len[1];
        l2_reg <= len[2];
        if (len[0] >= len[1] && len[0] >= len[2])
            mx_reg <= len[0];
        else if (len[1] >= len[2])
            mx_reg <= len[1];
        else
            mx_reg <= len[2];
    end

    tbik_dly #(.WD(2), .DP(L_ACOS - (L_LEN + 1))) u_rch_dly (
        .clk (clk),
        .d   (rch_reg),
        .q   (rch_d)
    );

    // stage E: least shift that brings the largest length below 2^30
    always_comb
    begin
        s_next = '0;
        for (int i = 0; i < LW; i++)
        begin
            if (i >= 30 && mx_reg[i])
                s_next = SW'(i - 29);
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg   <= s_next;
        l0e_reg <= l0_reg;
        l1e_reg <= l1_reg;
        l2e_reg <= l2_reg;
    end

    // stage F: scaled lengths
    always_ff @(posedge clk)
    begin
        a0_reg <= 30'(l0e_reg >> s_reg);
        a1_reg <= 30'(l1e_reg >> s_reg);
        a2_reg <= 30'(l2e_reg >> s_reg);
    end

    // stage G: products, stage H: law of cosines numerators and denominators
    logic [59:0] s0_reg, s1_reg, s2_reg, p20_reg, p10_reg;
    logic signed [63:0] nh_reg, dh_reg, nk_reg, dk_reg;

    always_ff @(posedge clk)
    begin
        s0_reg  <= a0_reg * a0_reg;
        s1_reg  <= a1_reg * a1_reg;
        s2_reg  <= a2_reg * a2_reg;
        p20_reg <= a2_reg * a0_reg;
        p10_reg <= a1_reg * a0_reg;
    end

    always_ff @(posedge clk)
    begin
        nh_reg <= 64'(s2_reg) + 64'(s0_reg) - 64'(s1_reg);
        dh_reg <= {3'b000, p20_reg, 1'b0};
        nk_reg <= 64'(s1_reg) + 64'(s0_reg) - 64'(s2_reg);
        dk_reg <= {3'b000, p10_reg, 1'b0};
    end

    tbik_pkg::cosv_t ch, ck;
    tbik_pkg::ang_t  acos_h, acos_k;

    tbik_div u_div_h (.clk(clk), .num(nh_reg), .den(dh_reg), .q(ch));
    tbik_div u_div_k (.clk(clk), .num(nk_reg), .den(dk_reg), .q(ck));

    tbik_acos u_acos_h (.clk(clk), .c(ch), .a(acos_h));
    tbik_acos u_acos_k (.clk(clk), .c(ck), .a(acos_k));

    // final: combine, round half up, saturate
    function automatic logic [AW-1:0] to_out(input tbik_pkg::ang_t v);
        tbik_pkg::ang_t r;
        begin
            r = (v + (tbik_pkg::ang_t'(1) <<< (SH - 1))) >>> SH;
            if (r > tbik_pkg::ang_t'((64'sd1 <<< (AW - 1)) - 1))
                return {1'b0, {(AW-1){1'b1}}};
            else if (r < -(tbik_pkg::ang_t'(1) <<< (AW - 1)))
                return {1'b1, {(AW-1){1'b0}}};
            else
                return r[AW-1:0];
        end
    endfunction

    tbik_pkg::ang_t hip_q, knee_q;
    logic           miss;
    logic [AW-1:0]  hip_angle_reg, knee_angle_reg;
    logic           reached_reg, degenerate_reg;

    always_comb
    begin
        miss = rch_d.degen || rch_d.far;
        if (miss)
        begin
            hip_q  = tbik_pkg::HALF_PI_Q30 + elev_d;
            knee_q = '0;
        end
        else
        begin
            hip_q  = tbik_pkg::HALF_PI_Q30 + elev_d + acos_h;
            knee_q = tbik_pkg::PI_Q30 + acos_k;
        end
    end

    always_ff @(posedge clk)
    begin
        hip_angle_reg  <= to_out(hip_q);
        knee_angle_reg <= to_out(knee_q);
        reached_reg    <= !miss;
        degenerate_reg <= rch_d.degen;
    end

    assign hip_angle  = hip_angle_reg;
    assign knee_angle = knee_angle_reg;
    assign reached    = reached_reg;
    assign degenerate = degenerate_reg;

    // checks
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, L_OUT))
        else $error("done without matching start");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(reached && degenerate))
        else $error("reached and degenerate both set");

    a_knee_straight: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !reached) |-> (knee_angle == '0))
        else $error("knee not straight on miss");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    // Flat-pipeline block: long fixed latency, one item per cycle, busy stays low.
    localparam int PIPE_LAT   = 140;
    localparam int DRAIN_WAIT = PIPE_LAT + 50;
    localparam int STALL_MAX  = 4 * PIPE_LAT + 2000;
    localparam int N_RANDOM   = 1630;

    localparam longint PI_FX   = 64'sd3373259426;
    localparam longint HPI_FX  = 64'sd1686629713;
    localparam longint ONE_FX  = 64'sd1073741824;

    // Joint index order of one item
    localparam int HX = 0, HY = 1, HZ = 2, KX = 3, KY = 4, KZ = 5;
    localparam int FX = 6, FY = 7, FZ = 8, GX = 9, GY = 10, GZ = 11;

    typedef logic signed [31:0] coord_t;

    typedef struct {
        coord_t c [12];
    } pose_t;

    typedef struct packed {
        logic [19:0] hip;
        logic [19:0] knee;
        logic        reached;
        logic        degenerate;
    } angles_t;

    // Directed row: pose plus an optional typed-in answer
    typedef struct {
        pose_t   pose;
        bit      typed;
        angles_t ans;
    } row_t;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    coord_t hip_x, hip_y, hip_z, knee_x, knee_y, knee_z;
    coord_t foot_x, foot_y, foot_z, goal_x, goal_y, goal_z;
    logic   done;
    logic signed [19:0] hip_angle, knee_angle;
    logic   reached, degenerate;

    two_bone_ik_angle_solver dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .hip_x(hip_x), .hip_y(hip_y), .hip_z(hip_z),
        .knee_x(knee_x), .knee_y(knee_y), .knee_z(knee_z),
        .foot_x(foot_x), .foot_y(foot_y), .foot_z(foot_z),
        .goal_x(goal_x), .goal_y(goal_y), .goal_z(goal_z),
        .done(done), .hip_angle(hip_angle), .knee_angle(knee_angle),
        .reached(reached), .degenerate(degenerate)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    angles_t pending_angles [$];
    bit      pending_typed  [$];
    angles_t typed_answers  [$];
    int      errors = 0;
    int      quiet_cycles = 0;

    // ---------------------------------------------------------------
    // Angle predictor
    // ---------------------------------------------------------------
    // truncated Q30 atan(2^-i)
    localparam longint ATAN_LUT [30] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
        15, 7, 3, 1
    };

    // bitwise integer root of a 128-bit value
    function automatic logic [63:0] int_root(input logic [127:0] v);
        logic [127:0] rem;
        logic [127:0] trial;
        logic [63:0]  root;
        begin
            rem  = '0;
            root = '0;
            for (int k = 63; k >= 0; k--)
            begin
                rem   = (rem << 2) | ((v >> (2 * k)) & 128'd3);
                trial = ({64'd0, root} << 2) | 128'd1;
                if (rem >= trial)
                begin
                    rem  = rem - trial;
                    root = (root << 1) | 64'd1;
                end
                else
                    root = root << 1;
            end
            return root;
        end
    endfunction

    function automatic logic [63:0] seg_len(input coord_t a [3], input coord_t b [3]);
        logic [127:0] acc;
        longint       d;
        logic [63:0]  m;
        begin
            acc = '0;
            for (int i = 0; i < 3; i++)
            begin
                d   = longint'(b[i]) - longint'(a[i]);
                m   = d < 0 ? -d : d;
                acc = acc + {64'd0, m} * {64'd0, m};
            end
            return int_root(acc);
        end
    endfunction

    // vectoring CORDIC, Q30 radians
    function automatic longint atan2_fx(input longint y, input longint x);
        logic [63:0] ax, ay, m;
        longint      cx, cy, z, dx, dy;
        begin
            if (x == 0 && y == 0)
                return 0;
            ax = x < 0 ? -x : x;
            ay = y < 0 ? -y : y;
            m  = ax > ay ? ax : ay;
            while (m >= (64'd1 << 30))
            begin
                ax = ax >> 1; ay = ay >> 1; m = m >> 1;
            end
            while (m < (64'd1 << 29))
            begin
                ax = ax << 1; ay = ay << 1; m = m << 1;
            end
            cx = ax;
            cy = ay;
            z  = 0;
            for (int i = 0; i < 30; i++)
            begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy >= 0)
                begin
                    cx += dx; cy -= dy; z += ATAN_LUT[i];
                end
                else
                begin
                    cx -= dx; cy += dy; z -= ATAN_LUT[i];
                end
            end
            if (x < 0)
                z = PI_FX - z;
            if (y < 0)
                z = -z;
            return z;
        end
    endfunction

    // law-of-cosines term for the angle between a and b, clamped, Q30
    function automatic longint cosine_fx(input longint a, input longint b, input longint c);
        longint      num, den;
        logic [63:0] r, q;
        bit          neg;
        begin
            num = a * a + b * b - c * c;
            den = 2 * a * b;
            if (den == 0)
                return num > 0 ? ONE_FX : (num < 0 ? -ONE_FX : 0);
            if (num >= den)
                return ONE_FX;
            if (num <= -den)
                return -ONE_FX;
            neg = num < 0;
            r   = neg ? -num : num;
            q   = '0;
            for (int i = 0; i < 30; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= den)
                begin
                    r = r - den;
                    q[0] = 1'b1;
                end
            end
            return neg ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic longint acos_fx(input longint c);
        logic [63:0] s2;
        begin
            s2 = (64'd1 << 60) - (c * c);
            return atan2_fx(longint'(int_root({64'd0, s2})), c);
        end
    endfunction

    // Q30 -> Q4.16, round half up, saturate
    function automatic logic [19:0] to_angle(input longint v);
        longint r;
        begin
            r = (v + (64'sd1 <<< 13)) >>> 14;
            if (r > 524287)
                r = 524287;
            if (r < -524288)
                r = -524288;
            return r[19:0];
        end
    endfunction

    function automatic angles_t solve_pose(input pose_t p);
        logic [63:0] upper, lower, reach, mx;
        longint      elev, u, w, g;
        int          s;
        angles_t     r;
        begin
            upper = seg_len(p.c[HX:HZ], p.c[KX:KZ]);
            lower = seg_len(p.c[KX:KZ], p.c[FX:FZ]);
            reach = seg_len(p.c[HX:HZ], p.c[GX:GZ]);
            elev  = atan2_fx(longint'(p.c[GY]) - longint'(p.c[HY]),
                             longint'(p.c[GZ]) - longint'(p.c[HZ]));
            r.degenerate = (upper == 0 || lower == 0 || reach == 0);
            if (r.degenerate || upper + lower < reach)
            begin
                r.hip     = to_angle(HPI_FX + elev);
                r.knee    = to_angle(0);
                r.reached = 1'b0;
                return r;
            end
            mx = upper > lower ? upper : lower;
            if (reach > mx)
                mx = reach;
            s = 0;
            while ((mx >> s) >= (64'd1 << 30))
                s++;
            u = upper >> s;
            w = lower >> s;
            g = reach >> s;
            r.hip     = to_angle(HPI_FX + elev + acos_fx(cosine_fx(g, u, w)));
            r.knee    = to_angle(PI_FX + acos_fx(cosine_fx(w, u, g)));
            r.reached = 1'b1;
            return r;
        end
    endfunction

    // ---------------------------------------------------------------
    // Input side: record an item at every accepting edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        pose_t p;
        if (rst_n && start && !busy)
        begin
            p.c = '{hip_x, hip_y, hip_z, knee_x, knee_y, knee_z,
                    foot_x, foot_y, foot_z, goal_x, goal_y, goal_z};
            pending_angles.push_back(solve_pose(p));
        end
    end

    task automatic report(input string what, input logic [19:0] want, input logic [19:0] got);
        begin
            $display("MISMATCH %s at %0t: expected %0h got %0h", what, $realtime, want, got);
            errors++;
        end
    endtask

    // Result side: every done strobe is compared with the oldest expectation
    always @(posedge clk)
    begin
        angles_t want;
        angles_t typed;
        bit      has_typed;
        if (rst_n && done)
        begin
            if (pending_angles.size() == 0)
            begin
                $display("MISMATCH result with no item outstanding at %0t", $realtime);
                errors++;
            end
            else
            begin
                want      = pending_angles.pop_front();
                has_typed = pending_typed.size() > 0 ? pending_typed.pop_front() : 1'b0;
                // typed-in rows double-check the predictor itself
                if (has_typed)
                begin
                    typed = typed_answers.pop_front();
                    if (typed != want)
                        report("predictor vs typed row", typed[41:22], want[41:22]);
                    want = typed;
                end
                if (hip_angle != want.hip)
                    report("hip_angle", want.hip, hip_angle);
                if (knee_angle != want.knee)
                    report("knee_angle", want.knee, knee_angle);
                if (reached != want.reached)
                    report("reached", want.reached, reached);
                if (degenerate != want.degenerate)
                    report("degenerate", want.degenerate, degenerate);
            end
        end
    end

    // Watchdog: cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_MAX)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Driver
    // ---------------------------------------------------------------
    task automatic drive_pose(input pose_t p, input bit may_idle);
        begin
            // random gaps before the item, about 31 in 100
            while (may_idle && $urandom_range(99) < 31)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            {hip_x, hip_y, hip_z}    <= {p.c[HX], p.c[HY], p.c[HZ]};
            {knee_x, knee_y, knee_z} <= {p.c[KX], p.c[KY], p.c[KZ]};
            {foot_x, foot_y, foot_z} <= {p.c[FX], p.c[FY], p.c[FZ]};
            {goal_x, goal_y, goal_z} <= {p.c[GX], p.c[GY], p.c[GZ]};
            start <= 1'b1;
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
    endtask

    function automatic coord_t rand_off(input int bits);
        begin
            return $signed($urandom) >>> (32 - bits);
        end
    endfunction

    // Well-formed leg with random content; goal along the hip-foot line,
    // sometimes pushed beyond reach.
    function automatic pose_t rand_leg();
        pose_t  p;
        int     sc;
        int     k;
        longint d;
        begin
            sc = $urandom_range(28, 4);
            for (int i = 0; i < 3; i++)
            begin
                p.c[HX + i] = rand_off(29);
                p.c[KX + i] = p.c[HX + i] + rand_off(sc);
                p.c[FX + i] = p.c[KX + i] + rand_off(sc);
            end
            k = $urandom_range(22);
            for (int i = 0; i < 3; i++)
            begin
                d = (longint'(p.c[FX + i]) - longint'(p.c[HX + i])) * k / 16;
                p.c[GX + i] = p.c[HX + i] + coord_t'(d) + rand_off($urandom_range(6, 1));
            end
            // collapsed bones, a goal on the hip and a goal level with the hip
            case ($urandom_range(15))
                0: p.c[KX:KZ] = p.c[HX:HZ];
                1: p.c[FX:FZ] = p.c[KX:KZ];
                2: p.c[GX:GZ] = p.c[HX:HZ];
                3: p.c[GY]    = p.c[HY];
                default: ;
            endcase
            return p;
        end
    endfunction

    function automatic pose_t rand_noise();
        pose_t p;
        begin
            foreach (p.c[i])
                p.c[i] = $urandom;
            return p;
        end
    endfunction

    function automatic row_t mk_row(input int v [12]);
        row_t r;
        begin
            foreach (v[i])
                r.pose.c[i] = v[i];
            r.typed = 1'b0;
            r.ans   = '0;
            return r;
        end
    endfunction

    localparam int MX = 32'h7fffffff;
    localparam int MN = 32'h80000000;
    localparam int U1 = 32'h00010000;   // 1.0

    initial
    begin
        row_t   rows [$];
        row_t   r;
        pose_t  p;
        logic [19:0] hp0;

        rst_n <= 1'b0;
        start <= 1'b0;
        {hip_x, hip_y, hip_z, knee_x, knee_y, knee_z} <= '0;
        {foot_x, foot_y, foot_z, goal_x, goal_y, goal_z} <= '0;

        // all joints at the origin: degenerate, hip straight up at pi/2
        hp0 = 20'd102944;
        r = mk_row('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        r.typed = 1'b1;
        r.ans   = '{hip: hp0, knee: 20'd0, reached: 1'b0, degenerate: 1'b1};
        rows.push_back(r);
        // zero upper bone
        rows.push_back(mk_row('{0, 0, 0, 0, 0, 0, 0, U1, 0, 0, 0, U1}));
        // zero lower bone
        rows.push_back(mk_row('{0, 0, 0, 0, U1, 0, 0, U1, 0, 0, U1, U1}));
        // goal on hip
        rows.push_back(mk_row('{U1, U1, U1, U1, 2*U1, U1, U1, 3*U1, U1, U1, U1, U1}));
        // goal out of reach
        rows.push_back(mk_row('{0, 0, 0, 0, U1, 0, 0, 2*U1, 0, 0, 0, 9*U1}));
        // reachable bent leg
        rows.push_back(mk_row('{0, 0, 0, 0, U1, 0, 0, U1, U1, 0, U1, U1}));
        // fully stretched: goal exactly at combined reach
        rows.push_back(mk_row('{0, 0, 0, 0, 0, U1, 0, 0, 2*U1, 0, 0, 2*U1}));
        // goal level with hip, behind it: elevation of +pi
        rows.push_back(mk_row('{0, 0, 0, 0, U1, 0, 0, U1, -U1, 0, 0, -U1}));
        // goal level, ahead
        rows.push_back(mk_row('{0, 0, 0, 0, U1, 0, 0, U1, U1, 0, 0, U1}));
        // straight down
        rows.push_back(mk_row('{0, 0, 0, 0, -U1, 0, 0, -2*U1, 0, 0, -U1, 0}));
        // tiny upper bone against huge lengths
        rows.push_back(mk_row('{0, 0, 0, 1, 0, 0, MX, MX, MX, MX, MX, MX - 5}));
        rows.push_back(mk_row('{MN, MN, MN, MN + 1, MN, MN, MX, MX, MX, MX, MX, MX}));
        // extremes of the coordinate range
        rows.push_back(mk_row('{MN, MN, MN, MX, MX, MX, MN, MN, MN, MX, MX, MX}));
        rows.push_back(mk_row('{MX, MX, MX, MN, MN, MN, MX, MX, MX, MN, MN, MN}));
        rows.push_back(mk_row('{MN, MX, MN, MX, MN, MX, MN, MX, MN, MX, MN, MX}));
        rows.push_back(mk_row('{MX, MX, MX, MX, MX, MX, MX, MX, MX, MX, MX, MX}));
        rows.push_back(mk_row('{-1, -1, -1, 0, 0, 0, -1, -1, -1, 0, 0, 0}));
        // one LSB bones
        rows.push_back(mk_row('{0, 0, 0, 0, 0, 1, 0, 1, 1, 0, 1, 0}));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            pending_typed.push_back(rows[i].typed);
            if (rows[i].typed)
                typed_answers.push_back(rows[i].ans);
            drive_pose(rows[i].pose, 1'b1);
        end

        // random part; a middle stretch runs back to back
        for (int n = 0; n < N_RANDOM; n++)
        begin
            p = ($urandom_range(99) < 80) ? rand_leg() : rand_noise();
            drive_pose(p, !(n >= 600 && n < 900));
        end
        start <= 1'b0;

        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tbik_pkg.sv
rtl/tbik_dly.sv
rtl/tbik_isqrt.sv
rtl/tbik_cordic.sv
rtl/tbik_div.sv
rtl/tbik_acos.sv
rtl/two_bone_ik_angle_solver.sv
dv/testbench.sv
